[design/rgs_pkg.sv]
package rgs_pkg;

  // coordinate width covers any image dimension the 7-bit registers can hold
  localparam int COORD_W = 7;
  localparam int DIR_W = 3;
  localparam int STK_W = 2 * COORD_W + DIR_W;

  // walk directions, tried in this order
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_GROW  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ADDR_REQ,
    ADDR_NBR,
    ADDR_CLR
  } addr_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_G_SEED,
    ST_G_DIR,
    ST_G_RD,
    ST_G_CMP,
    ST_G_POP,
    ST_Q_ME,
    ST_Q_DIR,
    ST_Q_CHK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic      cap;
    addr_sel_e addr_sel;
    logic      lbl_we;
    logic      pix_we;
    logic      seed_claim;
    logic      cur_init;
    logic      mul;
    logic      claim;
    logic      dir_inc;
    logic      pop;
    logic      bnd_chk;
    logic      res_ld;
    logic      clr_inc;
  } cmd_t;

  typedef struct packed {
    logic in_image;
    logic lab_nz;
    req_e req_type;
    logic lbl_zero;
    logic claim_ok;
    logic nbr_ok;
    logic dir_end;
    logic sp_zero;
    logic out_full;
    logic clr_last;
  } status_t;

endpackage

[design/rgs_if.sv]
// request channel
interface rgs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] col;
  logic [5:0] row;
  logic [7:0] pixel_value;
  logic [7:0] threshold;
  logic [7:0] region_label;

  modport source (output valid, req_type, col, row, pixel_value, threshold, region_label,
                  input ready);
  modport sink (input valid, req_type, col, row, pixel_value, threshold, region_label,
                output ready);
endinterface

// result channel
interface rgs_rsp_if;
  logic        valid;
  logic        ready;
  logic [12:0] region_size;
  logic        seed_taken;
  logic        on_boundary;

  modport source (output valid, region_size, seed_taken, on_boundary, input ready);
  modport sink (input valid, region_size, seed_taken, on_boundary, output ready);
endinterface

[design/region_growing_segmenter.sv]
// Seeded region growing over a stored grayscale image with a label per pixel.
// Requests: load writes one pixel and clears its label; grow floods depth-first
// from a seed over 4-neighbours (up, right, down, left), claiming unlabeled
// pixels within threshold of the running region mean; boundary query tells if
// any in-image neighbour has a different label. Every request gives one result
// word. After reset the label store is cleared one entry per cycle; while it is
// cleared no request is taken (register writes still are). A grow has each
// claimed pixel try four neighbours through one label/pixel read port, a
// multiply stage and a compare stage, and each finished frame costs a direction
// check and a stack pop. A result waiting on the output stalls the block until
// it is taken.
module region_growing_segmenter #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int LABEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rgs_req_if.sink     req_i,
  rgs_rsp_if.source   rsp_o
);

  localparam logic [6:0] WIDTH_RST = (64 > MAX_WIDTH) ? 7'(MAX_WIDTH) : 7'd64;
  localparam logic [6:0] HEIGHT_RST = (64 > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : 7'd64;

  function automatic logic [6:0] clamp(input logic [6:0] v, input int max_v);
    if (v == '0) clamp = 7'd1;
    else if (int'(v) > max_v) clamp = 7'(max_v);
    else clamp = v;
  endfunction

  logic [6:0]       width_q, height_q;
  logic             cfg_wr;
  rgs_pkg::cmd_t    cmd;
  rgs_pkg::status_t sts;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == rgs_pkg::REG_WIDTH) width_q <= clamp(pwdata[6:0], MAX_WIDTH);
      else height_q <= clamp(pwdata[6:0], MAX_HEIGHT);
    end
  end

  assign prdata = (paddr[2] == rgs_pkg::REG_HEIGHT) ? {25'd0, height_q} : {25'd0, width_q};

  rgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rgs_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LABEL_BITS (LABEL_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .width_i        (width_q),
    .height_i       (height_q),
    .req_type_i     (req_i.req_type),
    .col_i          (req_i.col),
    .row_i          (req_i.row),
    .pixel_value_i  (req_i.pixel_value),
    .threshold_i    (req_i.threshold),
    .region_label_i (req_i.region_label),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rsp_o          (rsp_o)
  );

endmodule

[design/rgs_ctrl.sv]
module rgs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  rgs_pkg::status_t sts_i,
  output rgs_pkg::cmd_t    cmd_o
);

  rgs_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.addr_sel = rgs_pkg::ADDR_REQ;
    req_ready_o = 1'b0;
    case (state_q)
      rgs_pkg::ST_CLEAR: begin
        cmd_o.addr_sel = rgs_pkg::ADDR_CLR;
        cmd_o.lbl_we = 1'b1;
        cmd_o.clr_inc = 1'b1;
        if (sts_i.clr_last) state_d = rgs_pkg::ST_IDLE;
      end
      rgs_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d = rgs_pkg::ST_DISPATCH;
        end
      end
      rgs_pkg::ST_DISPATCH: begin
        state_d = rgs_pkg::ST_FIN;
        if (sts_i.in_image) begin
          case (sts_i.req_type)
            rgs_pkg::REQ_LOAD: begin
              cmd_o.pix_we = 1'b1;
              cmd_o.lbl_we = 1'b1;
            end
            rgs_pkg::REQ_GROW: begin
              if (sts_i.lab_nz) state_d = rgs_pkg::ST_G_SEED;
            end
            rgs_pkg::REQ_QUERY: state_d = rgs_pkg::ST_Q_ME;
            default: state_d = rgs_pkg::ST_FIN;
          endcase
        end
      end
      // seed label and pixel are in the read registers here
      rgs_pkg::ST_G_SEED: begin
        if (sts_i.lbl_zero) begin
          cmd_o.seed_claim = 1'b1;
          cmd_o.lbl_we = 1'b1;
          state_d = rgs_pkg::ST_G_DIR;
        end else begin
          state_d = rgs_pkg::ST_FIN;
        end
      end
      rgs_pkg::ST_G_DIR: begin
        cmd_o.addr_sel = rgs_pkg::ADDR_NBR;
        if (sts_i.dir_end) begin
          state_d = sts_i.sp_zero ? rgs_pkg::ST_FIN : rgs_pkg::ST_G_POP;
        end else if (sts_i.nbr_ok) begin
          state_d = rgs_pkg::ST_G_RD;
        end else begin
          cmd_o.dir_inc = 1'b1;
        end
      end
      rgs_pkg::ST_G_RD: begin
        cmd_o.addr_sel = rgs_pkg::ADDR_NBR;
        cmd_o.mul = 1'b1;
        state_d = rgs_pkg::ST_G_CMP;
      end
      rgs_pkg::ST_G_CMP: begin
        cmd_o.addr_sel = rgs_pkg::ADDR_NBR;
        if (sts_i.claim_ok) begin
          cmd_o.claim = 1'b1;
          cmd_o.lbl_we = 1'b1;
        end else begin
          cmd_o.dir_inc = 1'b1;
        end
        state_d = rgs_pkg::ST_G_DIR;
      end
      rgs_pkg::ST_G_POP: begin
        cmd_o.pop = 1'b1;
        state_d = rgs_pkg::ST_G_DIR;
      end
      rgs_pkg::ST_Q_ME: begin
        cmd_o.cur_init = 1'b1;
        state_d = rgs_pkg::ST_Q_DIR;
      end
      rgs_pkg::ST_Q_DIR: begin
        cmd_o.addr_sel = rgs_pkg::ADDR_NBR;
        if (sts_i.dir_end) begin
          state_d = rgs_pkg::ST_FIN;
        end else if (sts_i.nbr_ok) begin
          state_d = rgs_pkg::ST_Q_CHK;
        end else begin
          cmd_o.dir_inc = 1'b1;
        end
      end
      rgs_pkg::ST_Q_CHK: begin
        cmd_o.addr_sel = rgs_pkg::ADDR_NBR;
        cmd_o.bnd_chk = 1'b1;
        cmd_o.dir_inc = 1'b1;
        state_d = rgs_pkg::ST_Q_DIR;
      end
      rgs_pkg::ST_FIN: begin
        if (!sts_i.out_full) begin
          cmd_o.res_ld = 1'b1;
          state_d = rgs_pkg::ST_IDLE;
        end
      end
      default: state_d = rgs_pkg::ST_IDLE;
    endcase
  end

endmodule

[design/rgs_dp.sv]
module rgs_dp #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int LABEL_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [6:0]          width_i,
  input  logic [6:0]          height_i,
  input  logic [1:0]          req_type_i,
  input  logic [5:0]          col_i,
  input  logic [5:0]          row_i,
  input  logic [7:0]          pixel_value_i,
  input  logic [7:0]          threshold_i,
  input  logic [7:0]          region_label_i,
  input  rgs_pkg::cmd_t       cmd_i,
  output rgs_pkg::status_t    sts_o,
  rgs_rsp_if.source           rsp_o
);

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(NPIX);
  localparam int CNT_W = $clog2(NPIX + 1);
  localparam int PW = CNT_W + 8;
  localparam int CW = rgs_pkg::COORD_W;
  localparam int DW = rgs_pkg::DIR_W;

  function automatic logic [AW-1:0] pos(input logic [CW-1:0] r, input logic [CW-1:0] c);
    pos = AW'(int'(r) * MAX_WIDTH + int'(c));
  endfunction

  // captured request
  rgs_pkg::req_e         req_q;
  logic [CW-1:0]         row_q, col_q;
  logic [7:0]            pix_q, thr_q;
  logic [LABEL_BITS-1:0] lab_q;

  // walk state
  logic [CW-1:0]         cur_row_q, cur_col_q;
  logic [DW-1:0]         dir_q;
  logic [AW-1:0]         sp_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [PW-1:0]         sum_q;
  logic [PW-1:0]         scaled_q, thrc_q;
  logic [7:0]            pix_nbr_q;
  logic                  lbl_zero_q;
  logic                  seed_q, bnd_q;
  logic [LABEL_BITS-1:0] me_q;
  logic [AW-1:0]         clr_q;
  logic                  out_valid_q;

  // memories
  logic [7:0]             pix_mem [NPIX];
  logic [LABEL_BITS-1:0]  lbl_mem [NPIX];
  logic [rgs_pkg::STK_W-1:0] stk_mem [NPIX];
  logic [7:0]             pix_rd_q;
  logic [LABEL_BITS-1:0]  lbl_rd_q;
  logic [rgs_pkg::STK_W-1:0] stk_rd_q;

  logic [CW-1:0]          nbr_row, nbr_col;
  logic                   nbr_ok;
  logic [AW-1:0]          addr;
  logic [LABEL_BITS-1:0]  lbl_wdata;
  logic [PW-1:0]          diff;

  // neighbour of the current pixel in the current direction
  always_comb begin
    nbr_row = cur_row_q;
    nbr_col = cur_col_q;
    nbr_ok = 1'b0;
    case (dir_q)
      rgs_pkg::DIR_UP: begin
        nbr_ok = cur_row_q != '0;
        nbr_row = cur_row_q - 1'b1;
      end
      rgs_pkg::DIR_RIGHT: begin
        nbr_ok = ({1'b0, cur_col_q} + 1'b1) < {1'b0, width_i};
        nbr_col = cur_col_q + 1'b1;
      end
      rgs_pkg::DIR_DOWN: begin
        nbr_ok = ({1'b0, cur_row_q} + 1'b1) < {1'b0, height_i};
        nbr_row = cur_row_q + 1'b1;
      end
      rgs_pkg::DIR_LEFT: begin
        nbr_ok = cur_col_q != '0;
        nbr_col = cur_col_q - 1'b1;
      end
      default: nbr_ok = 1'b0;
    endcase
  end

  // store address
  always_comb begin
    case (cmd_i.addr_sel)
      rgs_pkg::ADDR_NBR: addr = pos(nbr_row, nbr_col);
      rgs_pkg::ADDR_CLR: addr = clr_q;
      default:           addr = pos(row_q, col_q);
    endcase
  end

  assign lbl_wdata = (cmd_i.claim || cmd_i.seed_claim) ? lab_q : '0;

  // pixel store
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_we) pix_mem[addr] <= pix_q;
    pix_rd_q <= pix_mem[addr];
  end

  // label store
  always_ff @(posedge clk_i) begin
    if (cmd_i.lbl_we) lbl_mem[addr] <= lbl_wdata;
    lbl_rd_q <= lbl_mem[addr];
  end

  // walk stack, read port always looks at the top frame
  always_ff @(posedge clk_i) begin
    if (cmd_i.claim) stk_mem[sp_q] <= {cur_row_q, cur_col_q, dir_q + 1'b1};
    stk_rd_q <= stk_mem[sp_q - 1'b1];
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= rgs_pkg::req_e'(req_type_i);
      row_q <= {1'b0, row_i};
      col_q <= {1'b0, col_i};
      pix_q <= pixel_value_i;
      thr_q <= threshold_i;
      lab_q <= LABEL_BITS'(region_label_i);
    end
  end

  // mean test products, registered before the compare
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      scaled_q <= PW'(pix_rd_q * cnt_q);
      thrc_q <= PW'(thr_q * cnt_q);
      pix_nbr_q <= pix_rd_q;
      lbl_zero_q <= lbl_rd_q == '0;
    end
  end

  assign diff = (scaled_q >= sum_q) ? scaled_q - sum_q : sum_q - scaled_q;

  // current frame and boundary reference
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_claim || cmd_i.cur_init) begin
      cur_row_q <= row_q;
      cur_col_q <= col_q;
      dir_q <= rgs_pkg::DIR_UP;
      me_q <= lbl_rd_q;
    end else if (cmd_i.claim) begin
      cur_row_q <= nbr_row;
      cur_col_q <= nbr_col;
      dir_q <= rgs_pkg::DIR_UP;
    end else if (cmd_i.pop) begin
      {cur_row_q, cur_col_q, dir_q} <= stk_rd_q;
    end else if (cmd_i.dir_inc) begin
      dir_q <= dir_q + 1'b1;
    end
  end

  // region sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_claim) sum_q <= PW'(pix_rd_q);
    else if (cmd_i.claim) sum_q <= sum_q + PW'(pix_nbr_q);
  end

  // counters, flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      cnt_q <= '0;
      seed_q <= 1'b0;
      bnd_q <= 1'b0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_inc) clr_q <= clr_q + 1'b1;
      if (cmd_i.cap) begin
        cnt_q <= '0;
        seed_q <= 1'b0;
        bnd_q <= 1'b0;
      end else if (cmd_i.seed_claim) begin
        cnt_q <= CNT_W'(1);
        seed_q <= 1'b1;
        sp_q <= '0;
      end else if (cmd_i.claim) begin
        cnt_q <= cnt_q + 1'b1;
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - 1'b1;
      end else if (cmd_i.bnd_chk && (lbl_rd_q != me_q)) begin
        bnd_q <= 1'b1;
      end
      if (cmd_i.res_ld) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      rsp_o.region_size <= 13'(cnt_q);
      rsp_o.seed_taken <= seed_q;
      rsp_o.on_boundary <= bnd_q;
    end
  end

  assign rsp_o.valid = out_valid_q;

  // status to the controller
  always_comb begin
    sts_o.in_image = (col_q < width_i) && (row_q < height_i);
    sts_o.lab_nz = lab_q != '0;
    sts_o.req_type = req_q;
    sts_o.lbl_zero = lbl_rd_q == '0;
    sts_o.claim_ok = lbl_zero_q && (diff <= thrc_q);
    sts_o.nbr_ok = nbr_ok;
    sts_o.dir_end = dir_q == rgs_pkg::DIR_DONE;
    sts_o.sp_zero = sp_q == '0;
    sts_o.out_full = out_valid_q && !rsp_o.ready;
    sts_o.clr_last = clr_q == AW'(NPIX - 1);
  end

  // a pixel is only claimed when it was read as unlabeled
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.claim |-> lbl_zero_q)
    else $error("claim of a labeled pixel");

  // a pop needs an open frame
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.pop |-> sp_q != '0)
    else $error("walk stack underflow");

  // open frames stay fewer than claimed pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.claim |-> (CNT_W'(sp_q) < cnt_q))
    else $error("walk stack deeper than region");

  // a result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.res_ld |-> (!out_valid_q || rsp_o.ready))
    else $error("result overwritten");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int NPIX = 4096;
  localparam int LIMIT = 2000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] pixel;
    logic [7:0] thr;
    logic [7:0] label;
  } req_word_t;

  typedef struct packed {
    logic [12:0] size;
    logic        seed;
    logic        bnd;
  } rsp_word_t;

  // image and label mirror, predicts one result word per request word
  class seg_scoreboard;
    byte unsigned pix[NPIX];
    bit           loaded[NPIX];
    bit [7:0]     lbl[NPIX];
    int unsigned  stk_pos[NPIX];
    int unsigned  stk_dir[NPIX];
    int unsigned  cols, rows, depth, cnt;
    longint       sum;
    bit           touched_blank;
    rsp_word_t    pending[$];
    int           errors;

    function new();
      cols = 64;
      rows = 64;
      errors = 0;
      foreach (lbl[i]) begin
        lbl[i] = 0;
        loaded[i] = 0;
      end
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      int unsigned d;
      d = v & 32'h7f;
      if (d == 0) d = 1;
      if (d > 64) d = 64;
      if (idx == rgs_pkg::REG_WIDTH) cols = d;
      else rows = d;
    endfunction

    function bit fits(int unsigned np, int unsigned thr);
      longint scaled, diff;
      if (!loaded[np]) touched_blank = 1;
      scaled = longint'(pix[np]) * cnt;
      diff = scaled >= sum ? scaled - sum : sum - scaled;
      return diff <= longint'(thr) * cnt;
    endfunction

    function void claim(int unsigned p, bit [7:0] lab);
      if (!loaded[p]) touched_blank = 1;
      lbl[p] = lab;
      sum += pix[p];
      cnt++;
      stk_pos[depth] = p;
      stk_dir[depth] = rgs_pkg::DIR_UP;
      depth++;
    endfunction

    // depth-first flood, up/right/down/left
    function int unsigned flood(int unsigned c, int unsigned r, int unsigned thr,
                                bit [7:0] lab);
      int unsigned pc, pr, nc, nr, d;
      bit ok;
      depth = 0;
      sum = 0;
      cnt = 0;
      claim(r * 64 + c, lab);
      while (depth > 0) begin
        d = stk_dir[depth-1];
        if (d >= rgs_pkg::DIR_DONE) begin
          depth--;
          continue;
        end
        stk_dir[depth-1] = d + 1;
        pc = stk_pos[depth-1] % 64;
        pr = stk_pos[depth-1] / 64;
        nc = pc;
        nr = pr;
        ok = 0;
        if (d == rgs_pkg::DIR_UP) begin
          if (pr > 0) begin nr = pr - 1; ok = 1; end
        end else if (d == rgs_pkg::DIR_RIGHT) begin
          if (pc + 1 < cols) begin nc = pc + 1; ok = 1; end
        end else if (d == rgs_pkg::DIR_DOWN) begin
          if (pr + 1 < rows) begin nr = pr + 1; ok = 1; end
        end else begin
          if (pc > 0) begin nc = pc - 1; ok = 1; end
        end
        if (ok && lbl[nr*64+nc] == 0 && depth < NPIX) begin
          if (fits(nr * 64 + nc, thr)) claim(nr * 64 + nc, lab);
        end
      end
      return cnt;
    endfunction

    function bit grows(req_word_t w);
      return w.kind == rgs_pkg::REQ_GROW && w.col < cols && w.row < rows && w.label != 0
             && lbl[w.row*64+w.col] == 0;
    endfunction

    // a grow must never read a pixel that was never loaded
    function bit grow_safe(req_word_t w);
      bit [7:0] saved[NPIX];
      if (!grows(w)) return 1;
      saved = lbl;
      touched_blank = 0;
      void'(flood(w.col, w.row, w.thr, w.label));
      lbl = saved;
      return !touched_blank;
    endfunction

    function bit edge_label(int unsigned c, int unsigned r);
      bit [7:0] me;
      me = lbl[r*64+c];
      if (c > 0 && lbl[r*64+c-1] != me) return 1;
      if (c + 1 < cols && lbl[r*64+c+1] != me) return 1;
      if (r > 0 && lbl[(r-1)*64+c] != me) return 1;
      if (r + 1 < rows && lbl[(r+1)*64+c] != me) return 1;
      return 0;
    endfunction

    function void note_request(req_word_t w);
      rsp_word_t e;
      int unsigned p;
      e = '0;
      p = w.row * 64 + w.col;
      if (w.col < cols && w.row < rows) begin
        if (w.kind == rgs_pkg::REQ_LOAD) begin
          pix[p] = w.pixel;
          loaded[p] = 1;
          lbl[p] = 0;
        end else if (grows(w)) begin
          e.size = 13'(flood(w.col, w.row, w.thr, w.label));
          e.seed = 1;
        end else if (w.kind == rgs_pkg::REQ_QUERY) begin
          e.bnd = edge_label(w.col, w.row);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(rsp_word_t got);
      rsp_word_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word size=%0d seed=%0b bnd=%0b", $time,
                 got.size, got.seed, got.bnd);
        return;
      end
      e = pending.pop_front();
      if (got.size !== e.size) begin
        errors++;
        $display("%0t: region_size expected %0d actual %0d", $time, e.size, got.size);
      end
      if (got.seed !== e.seed) begin
        errors++;
        $display("%0t: seed_taken expected %0b actual %0b", $time, e.seed, got.seed);
      end
      if (got.bnd !== e.bnd) begin
        errors++;
        $display("%0t: on_boundary expected %0b actual %0b", $time, e.bnd, got.bnd);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgs_req_if req();
  rgs_rsp_if rsp();

  seg_scoreboard sb = new();
  int          burst_left = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int unsigned cycles = 0;

  region_growing_segmenter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready) sb.check_result({rsp.region_size, rsp.seed_taken,
                                                 rsp.on_boundary});
  end

  // receiver stalls, with a long hold-off on request
  initial begin
    rsp.ready = 0;
    forever begin
      @(negedge clk_i);
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 0;
      end else if (stall_mode == 0) begin
        rsp.ready <= 1;
      end else begin
        rsp.ready <= ($urandom_range(0, 9) >= (stall_mode == 1 ? 3 : 7));
      end
    end
  end

  task automatic go_quiet();
    req.valid <= 0;
    burst_left = 0;
  endtask

  // send one word, called and returning at a falling edge
  task automatic send_word(req_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req.valid <= 1;
    req.req_type <= w.kind;
    req.col <= w.col;
    req.row <= w.row;
    req.pixel_value <= w.pixel;
    req.threshold <= w.thr;
    req.region_label <= w.label;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    go_quiet();
    while (sb.pending.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    drain();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= (idx == rgs_pkg::REG_WIDTH) ? 3'd0 : 3'd4;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [1:0] k, int c, int r, int p, int t, int l);
    send_word({k, 6'(c), 6'(r), 8'(p), 8'(t), 8'(l)});
  endtask

  task automatic fill_image();
    for (int r = 0; r < sb.rows; r++)
      for (int c = 0; c < sb.cols; c++)
        send_fields(rgs_pkg::REQ_LOAD, c, r, ($urandom_range(0, 1) ? $urandom_range(100, 130)
                                                          : $urandom_range(0, 255)), 0, 0);
  endtask

  // random mix, mostly grows and queries inside the image
  task automatic random_words(int n);
    req_word_t w;
    int p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      w.pixel = 8'($urandom_range(0, 255));
      w.thr = 8'($urandom_range(0, 1) ? $urandom_range(0, 24) : $urandom_range(0, 255));
      w.label = $urandom_range(0, 7) == 0 ? 8'd0 : 8'($urandom_range(1, 255));
      w.col = 6'($urandom_range(0, sb.cols - 1));
      w.row = 6'($urandom_range(0, sb.rows - 1));
      if (p < 20) w.kind = rgs_pkg::REQ_LOAD;
      else if (p < 60) w.kind = rgs_pkg::REQ_GROW;
      else if (p < 85) w.kind = rgs_pkg::REQ_QUERY;
      else if (p < 93) begin
        w.kind = 2'($urandom_range(0, 3));
        w.col = 6'($urandom_range(0, 63));
        w.row = 6'($urandom_range(0, 63));
      end else w.kind = REQ_UNUSED;
      if (!sb.grow_safe(w)) w.kind = rgs_pkg::REQ_QUERY;
      send_word(w);
    end
  endtask

  initial begin
    req.valid = 0;
    req.req_type = '0;
    req.col = '0;
    req.row = '0;
    req.pixel_value = '0;
    req.threshold = '0;
    req.region_label = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: full-size image, no grow can be safe yet except rejected ones
    send_fields(rgs_pkg::REQ_LOAD, 0, 0, 0, 0, 0);
    send_fields(rgs_pkg::REQ_LOAD, 63, 63, 255, 0, 0);
    send_fields(rgs_pkg::REQ_QUERY, 63, 63, 0, 0, 0);
    send_fields(rgs_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
    send_fields(REQ_UNUSED, 5, 5, 255, 255, 255);
    send_fields(rgs_pkg::REQ_GROW, 0, 0, 0, 255, 0);

    // directed: small image
    write_reg(rgs_pkg::REG_WIDTH, 4);
    write_reg(rgs_pkg::REG_HEIGHT, 4);
    for (int i = 0; i < 16; i++)
      send_fields(rgs_pkg::REQ_LOAD, i % 4, i / 4, (i < 8) ? 10 + i : 255 - i, 0, 0);
    send_fields(rgs_pkg::REQ_GROW, 0, 0, 0, 0, 1);
    send_fields(rgs_pkg::REQ_GROW, 0, 0, 0, 255, 2);
    send_fields(rgs_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
    send_fields(rgs_pkg::REQ_QUERY, 1, 0, 0, 0, 0);
    send_fields(rgs_pkg::REQ_GROW, 3, 3, 0, 3, 255);
    send_fields(rgs_pkg::REQ_GROW, 1, 1, 0, 255, 128);
    send_fields(rgs_pkg::REQ_QUERY, 2, 2, 0, 0, 0);
    send_fields(rgs_pkg::REQ_LOAD, 1, 1, 77, 0, 0);
    send_fields(rgs_pkg::REQ_QUERY, 1, 1, 0, 0, 0);
    send_fields(rgs_pkg::REQ_GROW, 1, 1, 0, 0, 9);
    send_fields(rgs_pkg::REQ_LOAD, 4, 0, 1, 0, 0);
    send_fields(rgs_pkg::REQ_GROW, 0, 4, 0, 255, 3);
    send_fields(rgs_pkg::REQ_QUERY, 63, 63, 0, 0, 0);
    send_fields(REQ_UNUSED, 2, 2, 0, 0, 0);

    // receiver holds off while requests keep coming
    write_reg(rgs_pkg::REG_WIDTH, 5);
    write_reg(rgs_pkg::REG_HEIGHT, 4);
    fill_image();
    hold_left = 1500;
    random_words(30);

    // zero width clamps to one column
    write_reg(rgs_pkg::REG_WIDTH, 0);
    write_reg(rgs_pkg::REG_HEIGHT, 6);
    fill_image();
    random_words(20);

    // oversize width clamps to the maximum, single row partly loaded
    write_reg(rgs_pkg::REG_WIDTH, 127);
    write_reg(rgs_pkg::REG_HEIGHT, 1);
    random_words(14);

    // full size, grows only where every read pixel was loaded
    write_reg(rgs_pkg::REG_WIDTH, 64);
    write_reg(rgs_pkg::REG_HEIGHT, 100);
    random_words(14);

    drain();
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
design/rgs_pkg.sv
design/rgs_if.sv
design/rgs_ctrl.sv
design/rgs_dp.sv
design/region_growing_segmenter.sv
test/testbench.sv
